>>> rtl/bcn_pkg.sv
package bcn_pkg;

  typedef enum logic [2:0] {
    FMT_BC1  = 3'd0,
    FMT_BC2  = 3'd1,
    FMT_BC3  = 3'd2,
    FMT_BC4U = 3'd3,
    FMT_BC4S = 3'd4,
    FMT_BC5U = 3'd5,
    FMT_BC5S = 3'd6,
    FMT_NONE = 3'd7
  } fmt_t;

  localparam int unsigned NumRows = 4;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x / 3 for x < 766
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // x / 7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd2341;
    return p[21:14];
  endfunction

  // x / 5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd3277;
    return p[21:14];
  endfunction

  // x = 0..254 mapped to (x*255)/254
  function automatic logic [7:0] snorm_map(input logic [7:0] x);
    logic [8:0] s;
    s = {1'b0, x} + ((x >= 8'd254) ? 9'd1 : 9'd0);
    return s[7:0];
  endfunction

endpackage

>>> rtl/bcn_channel.sv
module bcn_channel
  import bcn_pkg::*;
(
  input  logic [63:0] half,
  input  logic        is_signed,
  output logic [7:0]  val [16]
);
  logic [7:0] pal [8];
  logic [7:0] b0, b1;
  assign b0 = half[7:0];
  assign b1 = half[15:8];

  always_comb begin
    logic signed [8:0] e0, e1;
    logic signed [12:0] s;
    logic [11:0] m;
    logic [7:0] q;
    logic signed [9:0] v;
    logic gt;
    e0 = is_signed ? 9'(signed'(b0)) : signed'({1'b0, b0});
    e1 = is_signed ? 9'(signed'(b1)) : signed'({1'b0, b1});
    gt = e0 > e1;
    for (int i = 0; i < 8; i++) begin
      s = '0;
      m = '0;
      q = '0;
      if (i == 0) v = 10'(e0);
      else if (i == 1) v = 10'(e1);
      else if (!gt && i == 6) v = is_signed ? -10'sd127 : 10'sd0;
      else if (!gt && i == 7) v = is_signed ? 10'sd127 : 10'sd255;
      else begin
        if (gt) s = 13'(8 - i) * 13'(e0) + 13'(i - 1) * 13'(e1);
        else s = 13'(6 - i) * 13'(e0) + 13'(i - 1) * 13'(e1);
        m = s[12] ? 12'(-s) : 12'(s);
        q = gt ? div7(m[10:0]) : div5(m[10:0]);
        v = s[12] ? -10'(signed'({2'b0, q})) : 10'(signed'({2'b0, q}));
      end
      if (is_signed) begin
        if (v < -10'sd127) v = -10'sd127;
        v = v + 10'sd127;
        pal[i] = snorm_map(v[7:0]);
      end else begin
        pal[i] = v[7:0];
      end
    end
    for (int t = 0; t < 16; t++) val[t] = pal[half[16 + 3*t +: 3]];
  end
endmodule

>>> rtl/bcn_colour.sv
module bcn_colour
  import bcn_pkg::*;
(
  input  logic [63:0] half,
  input  logic        punch,
  output logic [31:0] tex [16]
);
  logic [31:0] pal [4];

  always_comb begin
    logic [15:0] c0, c1;
    logic [7:0] p0 [3];
    logic [7:0] p1 [3];
    logic four;
    c0 = half[15:0];
    c1 = half[31:16];
    p0[0] = expand5(c0[15:11]); p0[1] = expand6(c0[10:5]); p0[2] = expand5(c0[4:0]);
    p1[0] = expand5(c1[15:11]); p1[1] = expand6(c1[10:5]); p1[2] = expand5(c1[4:0]);
    four = (c0 > c1) || !punch;
    pal[0] = {8'hFF, p0[2], p0[1], p0[0]};
    pal[1] = {8'hFF, p1[2], p1[1], p1[0]};
    pal[2][31:24] = 8'hFF;
    pal[3] = '0;
    for (int k = 0; k < 3; k++) begin
      if (four) begin
        pal[2][8*k +: 8] = div3({1'b0, p0[k], 1'b0} + 10'(p1[k]));
        pal[3][8*k +: 8] = div3(10'(p0[k]) + {1'b0, p1[k], 1'b0});
      end else begin
        pal[2][8*k +: 8] = 8'((9'(p0[k]) + 9'(p1[k])) >> 1);
      end
    end
    if (four) pal[3][31:24] = 8'hFF;
    for (int t = 0; t < 16; t++) tex[t] = pal[half[32 + 2*t +: 2]];
  end
endmodule

>>> rtl/bcn_texture_block_decoder.sv
// An accepted block is registered in lo/hi, then decoded into blk for output;
// rows follow one per cycle while out_stall is low, four output rows per block.
// A new block is accepted while the last row of the previous one is delivered.
// Reset (rst, synchronous) clears the format register to BC1 and empties the pipeline.
module bcn_texture_block_decoder
  import bcn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  row_index,
  output logic [31:0] pixel_0,
  output logic [31:0] pixel_1,
  output logic [31:0] pixel_2,
  output logic [31:0] pixel_3,
  output logic        last_row
);
  fmt_t        block_format;
  logic        in_full;
  logic [63:0] lo, hi;
  logic [31:0] tex [16];
  logic [31:0] blk [16];
  logic        blk_full;
  logic [1:0]  row;
  logic [31:0] ct [16];
  logic [7:0]  ca [16];
  logic [7:0]  cb [16];
  logic [63:0] col_half;
  logic        sgn, done, blk_load;

  always_ff @(posedge clk) begin
    if (rst) block_format <= FMT_BC1;
    else if (cfg_wr_en) block_format <= fmt_t'(cfg_wr_data);
  end

  assign done = out_valid && !out_stall && row == 2'd3;
  assign blk_load = in_full && (!blk_full || done);
  assign in_stall = in_full && !blk_load;
  assign col_half = (block_format == FMT_BC1) ? lo : hi;
  assign sgn = (block_format == FMT_BC4S) || (block_format == FMT_BC5S);

  bcn_colour u_col (.half(col_half), .punch(block_format == FMT_BC1), .tex(ct));
  bcn_channel u_cha (.half(lo), .is_signed(sgn), .val(ca));
  bcn_channel u_chb (.half(hi), .is_signed(sgn), .val(cb));

  always_comb begin
    for (int t = 0; t < 16; t++) begin
      unique case (block_format)
        FMT_BC1: tex[t] = ct[t];
        FMT_BC2: tex[t] = {8'(lo[4*t +: 4] * 8'd17), ct[t][23:0]};
        FMT_BC3: tex[t] = {ca[t], ct[t][23:0]};
        FMT_BC4U, FMT_BC4S: tex[t] = {8'hFF, ca[t], ca[t], ca[t]};
        FMT_BC5U, FMT_BC5S: tex[t] = {16'hFFFF, cb[t], ca[t]};
        default: tex[t] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      blk_full <= 1'b0;
      row <= '0;
    end else begin
      if (in_valid && !in_stall) in_full <= 1'b1;
      else if (blk_load) in_full <= 1'b0;
      if (blk_load) begin
        blk_full <= 1'b1;
        row <= '0;
      end else if (done) begin
        blk_full <= 1'b0;
        row <= '0;
      end else if (out_valid && !out_stall) begin
        row <= row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      lo <= block_low;
      hi <= block_high;
    end
    if (blk_load) blk <= tex;
  end

  assign out_valid = blk_full;
  assign row_index = row;
  assign last_row = row == 2'd3;
  assign pixel_0 = blk[{row, 2'd0}];
  assign pixel_1 = blk[{row, 2'd1}];
  assign pixel_2 = blk[{row, 2'd2}];
  assign pixel_3 = blk[{row, 2'd3}];
endmodule

>>> verif/tb_bcn_texture_block_decoder.sv
module tb_bcn_texture_block_decoder;
  import bcn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [1:0]  row;
    logic [31:0] p0, p1, p2, p3;
    logic        last;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] block_low = '0;
  logic [63:0] block_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  row_index;
  logic [31:0] pixel_0, pixel_1, pixel_2, pixel_3;
  logic        last_row;

  fmt_t  cur_fmt = FMT_BC1;
  row_t  pending_rows[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    stall_on = 1'b1;

  bcn_texture_block_decoder dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .block_low(block_low), .block_high(block_high),
    .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
    .pixel_0(pixel_0), .pixel_1(pixel_1), .pixel_2(pixel_2), .pixel_3(pixel_3),
    .last_row(last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] exp5(logic [4:0] v);
    int x;
    x = v;
    return 8'((x << 3) | (x >> 2));
  endfunction

  function automatic logic [7:0] exp6(logic [5:0] v);
    int x;
    x = v;
    return 8'((x << 2) | (x >> 4));
  endfunction

  function automatic void color_texels(logic [63:0] h, bit punch, output logic [31:0] tex[16]);
    int c0, c1, e[4][4], k, i;
    logic [31:0] pal[4];
    c0 = h[15:0];
    c1 = h[31:16];
    e[0][0] = exp5(h[15:11]); e[0][1] = exp6(h[10:5]); e[0][2] = exp5(h[4:0]);
    e[1][0] = exp5(h[31:27]); e[1][1] = exp6(h[26:21]); e[1][2] = exp5(h[20:16]);
    e[0][3] = 255; e[1][3] = 255; e[2][3] = 255; e[3][3] = 255;
    for (k = 0; k < 3; k++) begin
      if (c0 > c1 || !punch) begin
        e[2][k] = (2 * e[0][k] + e[1][k]) / 3;
        e[3][k] = (e[0][k] + 2 * e[1][k]) / 3;
      end else begin
        e[2][k] = (e[0][k] + e[1][k]) / 2;
        e[3][k] = 0;
      end
    end
    if (!(c0 > c1 || !punch)) e[3][3] = 0;
    for (i = 0; i < 4; i++)
      pal[i] = {8'(e[i][3]), 8'(e[i][2]), 8'(e[i][1]), 8'(e[i][0])};
    for (i = 0; i < 16; i++) tex[i] = pal[h[32 + 2 * i +: 2]];
  endfunction

  function automatic int trunc_div(int n, int d);
    if (n < 0) return -((-n) / d);
    return n / d;
  endfunction

  function automatic void channel_values(logic [63:0] h, bit sgn, output logic [7:0] v[16]);
    int e0, e1, pal[8], i, x;
    if (sgn) begin
      e0 = $signed(h[7:0]);
      e1 = $signed(h[15:8]);
    end else begin
      e0 = h[7:0];
      e1 = h[15:8];
    end
    pal[0] = e0; pal[1] = e1;
    if (e0 > e1) begin
      for (i = 0; i < 6; i++) pal[2 + i] = trunc_div((6 - i) * e0 + (1 + i) * e1, 7);
    end else begin
      for (i = 0; i < 4; i++) pal[2 + i] = trunc_div((4 - i) * e0 + (1 + i) * e1, 5);
      pal[6] = sgn ? -127 : 0;
      pal[7] = sgn ? 127 : 255;
    end
    for (i = 0; i < 16; i++) begin
      x = pal[h[16 + 3 * i +: 3]];
      if (sgn) begin
        if (x < -127) x = -127;
        x = (x + 127) * 255 / 254;
      end
      v[i] = 8'(x);
    end
  endfunction

  task automatic predict_rows(logic [63:0] lo, logic [63:0] hi);
    logic [31:0] tex[16];
    logic [7:0]  a[16], b[16];
    row_t r;
    int i;
    for (i = 0; i < 16; i++) tex[i] = '0;
    case (cur_fmt)
      FMT_BC1: color_texels(lo, 1'b1, tex);
      FMT_BC2: begin
        color_texels(hi, 1'b0, tex);
        for (i = 0; i < 16; i++) tex[i][31:24] = 8'(lo[4 * i +: 4] * 17);
      end
      FMT_BC3: begin
        color_texels(hi, 1'b0, tex);
        channel_values(lo, 1'b0, a);
        for (i = 0; i < 16; i++) tex[i][31:24] = a[i];
      end
      FMT_BC4U, FMT_BC4S: begin
        channel_values(lo, cur_fmt == FMT_BC4S, a);
        for (i = 0; i < 16; i++) tex[i] = {8'hFF, a[i], a[i], a[i]};
      end
      FMT_BC5U, FMT_BC5S: begin
        channel_values(lo, cur_fmt == FMT_BC5S, a);
        channel_values(hi, cur_fmt == FMT_BC5S, b);
        for (i = 0; i < 16; i++) tex[i] = {16'hFFFF, b[i], a[i]};
      end
      default: ;
    endcase
    for (i = 0; i < NumRows; i++) begin
      r.row = 2'(i);
      r.p0 = tex[4 * i]; r.p1 = tex[4 * i + 1]; r.p2 = tex[4 * i + 2]; r.p3 = tex[4 * i + 3];
      r.last = (i == NumRows - 1);
      pending_rows.push_back(r);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // output side: random stall, check each row
  always @(posedge clk) begin
    row_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        report("unexpected row", 32'(row_index), 0);
      end else begin
        w = pending_rows.pop_front();
        if (row_index !== w.row) report("row_index", 32'(row_index), 32'(w.row));
        if (pixel_0 !== w.p0) report("pixel_0", pixel_0, w.p0);
        if (pixel_1 !== w.p1) report("pixel_1", pixel_1, w.p1);
        if (pixel_2 !== w.p2) report("pixel_2", pixel_2, w.p2);
        if (pixel_3 !== w.p3) report("pixel_3", pixel_3, w.p3);
        if (last_row !== w.last) report("last_row", 32'(last_row), 32'(w.last));
      end
    end
    out_stall <= stall_on && (gap_len() != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays high into a back-to-back transaction; it drops only for a gap
  task automatic send_block(logic [63:0] lo, logic [63:0] hi);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    block_low <= lo;
    block_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_rows(lo, hi);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_format(fmt_t f);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_fmt = f;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    fmt_t f;
    for (int k = 0; k < 8; k++) begin
      f = fmt_t'(k);
      set_format(f);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'hFFFF_FFFF_0000_8001, 64'h1B1B_1B1B_8000_7F7F);
      send_block(64'h00E4_1B00_8081_7F80, 64'hE4E4_E4E4_7F81_0180);
    end
  endtask

  task automatic test_random();
    fmt_t f;
    logic [63:0] lo, hi;
    for (int n = 0; n < 420; n++) begin
      if (n % 30 == 0) begin
        f = fmt_t'($urandom_range(0, 7));
        stall_on = (n % 90 != 60);
        set_format(f);
      end
      lo = rand64();
      hi = rand64();
      // equal or ordered endpoints for palette branches
      case ($urandom_range(0, 3))
        0: begin lo[15:8] = lo[7:0]; hi[15:8] = hi[7:0]; end
        1: lo[31:16] = lo[15:0];
        default: ;
      endcase
      send_block(lo, hi);
    end
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    predict_rows(0, 0);
    pending_rows.delete();
    test_directed();
    test_random();
    set_format(FMT_BC1);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bcn_pkg.sv
rtl/bcn_channel.sv
rtl/bcn_colour.sv
rtl/bcn_texture_block_decoder.sv
verif/tb_bcn_texture_block_decoder.sv
